### rtl/core/utf8_dec_pkg.sv
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned PosWidth = 32;

  localparam logic [PosWidth-1:0] BadCodePoint = '1;

  // Byte masks and patterns
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'he0;
  localparam logic [7:0] Lead2Match = 8'hc0;
  localparam logic [7:0] Lead3Mask  = 8'hf0;
  localparam logic [7:0] Lead3Match = 8'he0;
  localparam logic [7:0] Lead4Mask  = 8'hf8;
  localparam logic [7:0] Lead4Match = 8'hf0;
  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContMatch  = 8'h80;
  localparam logic [7:0] ContBits   = 8'h3f;
  localparam logic [7:0] AsciiBits  = 8'h7f;
  localparam logic [7:0] Lead2Bits  = 8'h1f;
  localparam logic [7:0] Lead3Bits  = 8'h0f;
  localparam logic [7:0] Lead4Bits  = 8'h07;

  typedef enum logic [2:0] {
    LEAD_STRAY,
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR
  } lead_kind_e;

  typedef struct packed {
    lead_kind_e  kind;
    logic [6:0]  bits;       // payload bits of the lead byte
    logic [1:0]  remaining;  // continuation bytes to follow
  } lead_info_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [PosWidth-1:0] prior_code_point;
    logic [PosWidth-1:0] start_offset;
    logic                malformed;
  } out_item_t;

endpackage

### rtl/core/utf8_dec_lead.sv
// ----------------------------------------------------------------------------
// utf8_dec_lead
// Classifies a lead byte: sequence length, payload bits, follow-up count.
// ----------------------------------------------------------------------------
module utf8_dec_lead (
  input  logic [7:0]               byte_i,
  output utf8_dec_pkg::lead_info_t info_o
);
  import utf8_dec_pkg::*;

  always_comb begin
    info_o = '{kind: LEAD_STRAY, bits: '0, remaining: 2'd0};
    if ((byte_i & AsciiMask) == 8'h00) begin
      info_o.kind = LEAD_ASCII;
      info_o.bits = byte_i[6:0] & AsciiBits[6:0];
    end else if ((byte_i & Lead2Mask) == Lead2Match) begin
      info_o.kind      = LEAD_TWO;
      info_o.bits      = byte_i[6:0] & Lead2Bits[6:0];
      info_o.remaining = 2'd1;
    end else if ((byte_i & Lead3Mask) == Lead3Match) begin
      info_o.kind      = LEAD_THREE;
      info_o.bits      = byte_i[6:0] & Lead3Bits[6:0];
      info_o.remaining = 2'd2;
    end else if ((byte_i & Lead4Mask) == Lead4Match) begin
      info_o.kind      = LEAD_FOUR;
      info_o.bits      = byte_i[6:0] & Lead4Bits[6:0];
      info_o.remaining = 2'd3;
    end
  end

endmodule

### rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder, one buffer byte per item, one result per sequence.
// ----------------------------------------------------------------------------
// Output: a result appears on the output register in the cycle after the byte
// that completes (or breaks) its sequence is accepted.
// Throughput: one byte per cycle; the output register is the only stage, so
// input is held off only while a result waits under out_stall_i.
// Reset: rst_ni clears all sequence state, the byte offset and the output valid flag.
module utf8_stream_decoder (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  utf8_dec_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output utf8_dec_pkg::out_item_t out_item_o
);
  import utf8_dec_pkg::*;

  logic [1:0]          rem_q, rem_d;
  logic [CpWidth-1:0]  acc_q, acc_d;
  logic                bad_q, bad_d;
  logic [PosWidth-1:0] start_q, start_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] last_q, last_d;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic       accept;
  logic       emit;
  out_item_t  res;
  lead_info_t lead;
  logic [7:0] b;
  logic       eob;
  logic       cont_bad;
  logic [CpWidth-1:0] acc_shift;
  logic [1:0]         rem_dec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_item_i.data_byte;
  assign eob        = in_item_i.end_of_buffer;

  utf8_dec_lead u_lead (
    .byte_i (b),
    .info_o (lead)
  );

  assign cont_bad  = bad_q || ((b & ContMask) != ContMatch);
  assign acc_shift = {acc_q[CpWidth-7:0], b[5:0] & ContBits[5:0]};
  assign rem_dec   = rem_q - 2'd1;

  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    start_d = start_q;
    last_d  = last_q;
    pos_d   = pos_q + PosWidth'(1);
    emit    = 1'b0;
    res     = '{code_point: '0, prior_code_point: last_q,
                start_offset: start_q, malformed: 1'b1};

    if (rem_q == 2'd0) begin
      start_d          = pos_q;
      res.start_offset = pos_q;
      case (lead.kind)
        LEAD_STRAY: begin
          emit = 1'b1;
        end
        LEAD_ASCII: begin
          emit           = 1'b1;
          res.code_point = CpWidth'(lead.bits);
          res.malformed  = 1'b0;
          last_d         = PosWidth'(lead.bits);
        end
        default: begin
          acc_d = CpWidth'(lead.bits);
          bad_d = 1'b0;
          rem_d = lead.remaining;
          emit  = eob;  // cut off on the lead byte itself
        end
      endcase
    end else begin
      bad_d = cont_bad;
      acc_d = acc_shift;
      rem_d = rem_dec;
      if (rem_dec == 2'd0) begin
        emit = 1'b1;
        if (cont_bad) begin
          last_d = BadCodePoint;
        end else begin
          res.code_point = acc_shift;
          res.malformed  = 1'b0;
          last_d         = PosWidth'(acc_shift);
        end
      end else begin
        emit = eob;  // truncated sequence
      end
    end

    // End of buffer: drop all state
    if (eob) begin
      rem_d   = '0;
      acc_d   = '0;
      bad_d   = 1'b0;
      start_d = '0;
      pos_d   = '0;
      last_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      start_q     <= '0;
      pos_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rem_q   <= rem_d;
        acc_q   <= acc_d;
        bad_q   <= bad_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        last_q  <= last_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/core/utf8_dec_checker.sv
// ----------------------------------------------------------------------------
// utf8_dec_checker
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8_dec_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input utf8_dec_pkg::in_item_t  in_item_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input utf8_dec_pkg::out_item_t out_item_o
);
  import utf8_dec_pkg::*;

  // Input is held off only by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // A stalled input item holds until accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_item_i)))
    else $error("stalled input item changed");

  // A waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // Malformed results carry no codepoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.malformed) |-> (out_item_o.code_point == '0))
    else $error("malformed result with nonzero codepoint");

  // Prior codepoint is either the bad marker or fits in 21 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.prior_code_point != BadCodePoint))
      |-> (out_item_o.prior_code_point[PosWidth-1:CpWidth] == '0))
    else $error("prior codepoint out of range");

endmodule

bind utf8_stream_decoder utf8_dec_checker u_utf8_dec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### dv/utf8_dec_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_tb_pkg
// Scoreboard of the UTF-8 stream decoder testbench: predicts the codepoint
// results of the accepted bytes and checks the results that leave the block.
// ----------------------------------------------------------------------------
package utf8_dec_tb_pkg;

  import utf8_dec_pkg::*;

  class utf8_scoreboard;

    logic [1:0]          conts_left;
    logic [CpWidth-1:0]  partial_cp;
    logic                cont_broken;
    logic [PosWidth-1:0] seq_offset;
    logic [PosWidth-1:0] next_offset;
    logic [PosWidth-1:0] last_cp;

    out_item_t   pending_codepoints[$];
    int unsigned mismatch_count;

    function new();
      clear_state();
      mismatch_count = 0;
    endfunction

    function void clear_state();
      conts_left  = '0;
      partial_cp  = '0;
      cont_broken = 1'b0;
      seq_offset  = '0;
      next_offset = '0;
      last_cp     = '0;
    endfunction

    function lead_kind_e classify(logic [7:0] b);
      if ((b & AsciiMask) == 8'h00) return LEAD_ASCII;
      if ((b & Lead2Mask) == Lead2Match) return LEAD_TWO;
      if ((b & Lead3Mask) == Lead3Match) return LEAD_THREE;
      if ((b & Lead4Mask) == Lead4Match) return LEAD_FOUR;
      return LEAD_STRAY;
    endfunction

    function out_item_t make_result(logic [CpWidth-1:0] cp, logic [PosWidth-1:0] offset,
                                    logic bad);
      out_item_t res;
      res.code_point       = cp;
      res.prior_code_point = last_cp;
      res.start_offset     = offset;
      res.malformed        = bad;
      return res;
    endfunction

    // Advance the decoder state by one accepted byte; queue its result if any.
    function void note_byte(in_item_t item);
      logic [7:0] b;
      lead_kind_e kind;
      b = item.data_byte;
      if (conts_left == 2'd0) begin
        seq_offset = next_offset;
        kind = classify(b);
        case (kind)
          LEAD_STRAY: begin
            pending_codepoints.push_back(make_result('0, next_offset, 1'b1));
          end
          LEAD_ASCII: begin
            pending_codepoints.push_back(make_result(CpWidth'(b & AsciiBits),
                                                     next_offset, 1'b0));
            last_cp = PosWidth'(b & AsciiBits);
          end
          default: begin
            cont_broken = 1'b0;
            if (kind == LEAD_TWO) begin
              partial_cp = CpWidth'(b & Lead2Bits);
              conts_left = 2'd1;
            end else if (kind == LEAD_THREE) begin
              partial_cp = CpWidth'(b & Lead3Bits);
              conts_left = 2'd2;
            end else begin
              partial_cp = CpWidth'(b & Lead4Bits);
              conts_left = 2'd3;
            end
            // buffer ends right on the lead byte
            if (item.end_of_buffer)
              pending_codepoints.push_back(make_result('0, next_offset, 1'b1));
          end
        endcase
      end else begin
        if ((b & ContMask) != ContMatch) cont_broken = 1'b1;
        partial_cp = {partial_cp[CpWidth-7:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          if (cont_broken) begin
            pending_codepoints.push_back(make_result('0, seq_offset, 1'b1));
            last_cp = BadCodePoint;
          end else begin
            pending_codepoints.push_back(make_result(partial_cp, seq_offset, 1'b0));
            last_cp = PosWidth'(partial_cp);
          end
        end else if (item.end_of_buffer) begin
          pending_codepoints.push_back(make_result('0, seq_offset, 1'b1));
        end
      end
      next_offset = next_offset + 1;
      if (item.end_of_buffer) clear_state();
    endfunction

    task report_mismatch(string what, logic [PosWidth-1:0] got, logic [PosWidth-1:0] want);
      $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_codepoint(out_item_t got);
      out_item_t want;
      if (pending_codepoints.size() == 0) begin
        report_mismatch("unexpected result, code_point", PosWidth'(got.code_point), '0);
      end else begin
        want = pending_codepoints.pop_front();
        if (got.code_point !== want.code_point)
          report_mismatch("code_point", PosWidth'(got.code_point), PosWidth'(want.code_point));
        if (got.prior_code_point !== want.prior_code_point)
          report_mismatch("prior_code_point", got.prior_code_point, want.prior_code_point);
        if (got.start_offset !== want.start_offset)
          report_mismatch("start_offset", got.start_offset, want.start_offset);
        if (got.malformed !== want.malformed)
          report_mismatch("malformed", PosWidth'(got.malformed), PosWidth'(want.malformed));
      end
    endtask

    function int unsigned pending_count();
      return pending_codepoints.size();
    endfunction

  endclass

endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the UTF-8 stream decoder directed and random byte buffers (valid,
// broken, stray and cut-off sequences) under random idling on both sides and
// checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;

  import utf8_dec_pkg::*;
  import utf8_dec_tb_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ByteTarget   = 725;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned HoldAtByte   = 500;
  localparam int unsigned CalmFirst    = 250;
  localparam int unsigned CalmLast     = 400;
  localparam int unsigned IdlePercent  = 15;
  localparam int unsigned DrainCycles  = 10;

  logic      clk;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  utf8_scoreboard sb = new();

  int unsigned sent_count;
  int unsigned cycle_count;
  logic        calm;
  logic [7:0]  buf_bytes[$];

  assign calm = (sent_count >= CalmFirst) && (sent_count < CalmLast);

  utf8_stream_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HoldAtByte) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) sb.check_codepoint(out_item);
  end

  // Send buf_bytes as one buffer; flag the last byte as its end.
  task automatic send_buffer();
    in_item_t item;
    for (int i = 0; i < buf_bytes.size(); i++) begin
      item.data_byte     = buf_bytes[i];
      item.end_of_buffer = (i == buf_bytes.size() - 1);
      while (!calm && $urandom_range(0, 99) < IdlePercent) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_byte(item);
      sent_count++;
      @(negedge clk);
    end
    buf_bytes.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      1:       return {1'b0, 7'($urandom_range(0, 127))};
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  // Append one sequence of len bytes; break one continuation if asked.
  task automatic push_sequence(int unsigned len, bit broken);
    int unsigned bad_at;
    logic [7:0]  b;
    bad_at = $urandom_range(1, len - 1);
    buf_bytes.push_back(lead_byte(len));
    for (int unsigned k = 1; k < len; k++) begin
      b = cont_byte();
      if (broken && k == bad_at) begin
        do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
      end
      buf_bytes.push_back(b);
    end
  endtask

  task automatic build_random_buffer();
    int unsigned n_seq;
    int unsigned pick;
    int unsigned len;
    n_seq = $urandom_range(1, 10);
    for (int unsigned s = 0; s < n_seq; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_sequence($urandom_range(1, 4), 1'b0);
      end else if (pick < 85) begin
        push_sequence($urandom_range(2, 4), 1'b1);
      end else if (pick < 95) begin
        buf_bytes.push_back($urandom_range(0, 1) ? {2'b10, 6'($urandom_range(0, 63))}
                                                 : {5'b11111, 3'($urandom_range(0, 7))});
      end else begin
        buf_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut the buffer off inside a sequence
    if ($urandom_range(0, 99) < 25) begin
      len = $urandom_range(2, 4);
      buf_bytes.push_back(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) buf_bytes.push_back(cont_byte());
    end
  endtask

  initial begin
    sent_count = 0;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // ASCII extremes, every sequence length, largest 21-bit value, stray bytes,
    // a broken sequence followed by ASCII, and a lead byte that ends the buffer
    buf_bytes = '{8'h00, 8'h7f, 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac,
                  8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf7, 8'hbf, 8'hbf, 8'hbf,
                  8'h80, 8'hff, 8'he2, 8'h41, 8'hc0, 8'h41, 8'hc3};
    send_buffer();
    // buffer ends in the middle of a sequence
    buf_bytes = '{8'he2, 8'h82};
    send_buffer();
    // buffer ends on a plain ASCII byte
    buf_bytes = '{8'h41};
    send_buffer();

    while (sent_count < ByteTarget) begin
      build_random_buffer();
      send_buffer();
    end
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/utf8_dec_pkg.sv
rtl/core/utf8_dec_lead.sv
rtl/core/utf8_stream_decoder.sv
rtl/core/utf8_dec_checker.sv
dv/utf8_dec_tb_pkg.sv
dv/testbench.sv
